/* sv/graceful_power_sequencer_unit_assert.svh */
// Assertion macros for the power sequencer; clocked on clk_i, GPS_ASSERT disabled in reset (rst_ni low).
`ifndef GRACEFUL_POWER_SEQUENCER_UNIT_ASSERT_SVH
`define GRACEFUL_POWER_SEQUENCER_UNIT_ASSERT_SVH

// Checked only outside reset.
`define GPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gps assertion failed");

// Checked in reset too.
`define GPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("gps assertion failed");

`endif

/* sv/gps_pkg.sv */
`default_nettype none
package gps_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_BROWNOUT = 2'd1,
    MODE_SHUTDOWN = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CFG_DEBOUNCE_TICKS  = 3'd0,
    CFG_BROWNOUT_TICKS  = 3'd1,
    CFG_BLINK_TICKS     = 3'd2,
    CFG_SHUTDOWN_BLINKS = 3'd3,
    CFG_WAKE_ON_SUPPLY  = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] brownout_ticks;
    logic [15:0] blink_ticks;
    logic [5:0]  shutdown_blinks;
    logic        wake_on_supply;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    debounce_ticks:  16'd5,
    brownout_ticks:  16'd200,
    blink_ticks:     16'd50,
    shutdown_blinks: 6'd36,
    wake_on_supply:  1'b0
  };

  // last_levels: bit0 safe_n, bit1 button_n, bit2 ext_power
  typedef struct packed {
    mode_e       mode;
    logic        power_on;
    logic        led_on;
    logic        halt_on;
    logic [5:0]  blink_count;
    logic [15:0] slow_timer;
    logic        slow_running;
    logic [15:0] deb_timer;
    logic        deb_active;
    logic [2:0]  last_levels;
  } state_t;

  localparam state_t StateReset = '{
    mode:         MODE_IDLE,
    power_on:     1'b0,
    led_on:       1'b0,
    halt_on:      1'b0,
    blink_count:  6'd0,
    slow_timer:   16'd0,
    slow_running: 1'b0,
    deb_timer:    16'd0,
    deb_active:   1'b0,
    last_levels:  3'b011
  };

endpackage
`default_nettype wire

/* sv/gps_core.sv */
`default_nettype none
// Next-state logic for one tick: timers first, then SAFE/button, then supply edges.
module gps_core import gps_pkg::*; (
  input  var state_t     st_i,
  input  var cfg_t       cfg_i,
  input  var logic [2:0] levels_i,
  output state_t         st_o
);

  always_comb begin
    state_t      s;
    logic        safe;
    logic        btn;
    logic        ext;
    logic [2:0]  changed;
    logic [16:0] deb_inc;
    logic [16:0] slow_inc;
    logic [15:0] period;
    logic [5:0]  bc_inc;

    s        = st_i;
    safe     = levels_i[0];
    btn      = levels_i[1];
    ext      = levels_i[2];
    changed  = levels_i ^ st_i.last_levels;
    deb_inc  = {1'b0, st_i.deb_timer} + 17'd1;
    slow_inc = '0;
    period   = '0;
    bc_inc   = '0;

    if (s.deb_active) begin
      if (deb_inc >= {1'b0, cfg_i.debounce_ticks}) begin
        s.deb_active = 1'b0;
        s.deb_timer  = '0;
        if (!btn) begin
          if (!s.power_on && ext) begin
            if (s.mode == MODE_IDLE) begin
              s.power_on = 1'b1;
              s.led_on   = 1'b1;
            end
          end else if (s.power_on) begin
            s.halt_on      = 1'b1;
            s.mode         = MODE_SHUTDOWN;
            s.slow_timer   = '0;
            s.slow_running = 1'b1;
          end
        end
      end else begin
        s.deb_timer = deb_inc[15:0];
      end
    end

    // a shutdown started by the debounce above already counts this tick
    if (s.slow_running) begin
      period   = (s.mode == MODE_SHUTDOWN) ? cfg_i.blink_ticks : cfg_i.brownout_ticks;
      slow_inc = {1'b0, s.slow_timer} + 17'd1;
      if (slow_inc >= {1'b0, period}) begin
        s.slow_timer = '0;
        case (s.mode)
          MODE_BROWNOUT: begin
            s.slow_running = 1'b0;
            if (!ext) begin
              s.halt_on      = 1'b1;
              s.mode         = MODE_SHUTDOWN;
              s.slow_timer   = '0;
              s.slow_running = 1'b1;
            end
          end
          MODE_SHUTDOWN: begin
            bc_inc        = s.blink_count + 6'd1;
            s.blink_count = bc_inc;
            if (bc_inc < cfg_i.shutdown_blinks) begin
              s.led_on = ~s.led_on;
            end else begin
              s.power_on     = 1'b0;
              s.led_on       = 1'b0;
              s.halt_on      = 1'b0;
              s.mode         = MODE_IDLE;
              s.blink_count  = '0;
              s.slow_running = 1'b0;
              s.slow_timer   = '0;
            end
          end
          default: begin
            s.slow_running = 1'b0;
          end
        endcase
      end else begin
        s.slow_timer = slow_inc[15:0];
      end
    end

    if (changed[1:0] != 2'b00) begin
      if (!safe) begin
        s.power_on     = 1'b0;
        s.led_on       = 1'b0;
        s.halt_on      = 1'b0;
        s.mode         = MODE_IDLE;
        s.blink_count  = '0;
        s.slow_running = 1'b0;
        s.slow_timer   = '0;
      end
      if (!btn) begin
        s.deb_timer  = '0;
        s.deb_active = 1'b1;
      end
    end

    if (changed[2]) begin
      if (ext) begin
        if (s.mode != MODE_SHUTDOWN) begin
          s.mode = MODE_IDLE;
          if (cfg_i.wake_on_supply) begin
            s.power_on = 1'b1;
            s.led_on   = 1'b1;
          end
        end
      end else if (s.power_on) begin
        s.mode         = MODE_BROWNOUT;
        s.slow_timer   = '0;
        s.slow_running = 1'b1;
      end
    end

    s.last_levels = levels_i;
    st_o          = s;
  end

endmodule
`default_nettype wire

/* sv/graceful_power_sequencer_unit.sv */
// Power sequencer, one input beat per base tick.
// The result beat is registered and valid in the cycle after the input beat is taken.
// Throughput: one beat per cycle; the single output register takes a new result
// whenever it is empty or its beat leaves in the same cycle.
// Reset (rst_ni low, asynchronous): host off, idle, timers stopped, config registers at defaults.
`default_nettype none
module graceful_power_sequencer_unit import gps_pkg::*; (
  input  var logic                clk_i,
  input  var logic                rst_ni,
  input  var logic                s_axis_tvalid,
  output logic                    s_axis_tready,
  // [0] safe_n, [1] button_n, [2] ext_power, [7:3] zero
  input  var logic [7:0]          s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  var logic                m_axis_tready,
  // [0] power_enable, [1] halt_request, [2] led_drive, [4:3] mode, [7:5] zero
  output logic [7:0]              m_axis_tdata,
  input  var logic                cfg_valid_i,
  output logic                    cfg_ready_o,
  input  var logic [CfgIdxW-1:0]  cfg_index_i,
  input  var logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t       cfg_q;
  state_t     st_q, st_d;
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       in_beat;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEBOUNCE_TICKS:  cfg_q.debounce_ticks  <= cfg_data_i;
        CFG_BROWNOUT_TICKS:  cfg_q.brownout_ticks  <= cfg_data_i;
        CFG_BLINK_TICKS:     cfg_q.blink_ticks     <= cfg_data_i;
        CFG_SHUTDOWN_BLINKS: cfg_q.shutdown_blinks <= cfg_data_i[5:0];
        CFG_WAKE_ON_SUPPLY:  cfg_q.wake_on_supply  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  gps_core u_core (
    .st_i     (st_q),
    .cfg_i    (cfg_q),
    .levels_i (s_axis_tdata[2:0]),
    .st_o     (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_beat) begin
        st_q <= st_d;
      end
      if (in_beat) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_data_q <= {3'b000, st_d.mode, st_d.led_on, st_d.halt_on, st_d.power_on};
    end
  end

endmodule
`default_nettype wire

/* sv/gps_checker.sv */
`default_nettype none
`include "graceful_power_sequencer_unit_assert.svh"
module gps_checker import gps_pkg::*; (
  input var logic       clk_i,
  input var logic       rst_ni,
  input var logic       s_axis_tready,
  input var logic       m_axis_tvalid,
  input var logic       m_axis_tready,
  input var logic [7:0] m_axis_tdata
);

  // halt is only raised on a powered host and cleared together with power
  `GPS_ASSERT(a_halt_needs_power, m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
  // brownout wait and shutdown only exist while powered
  `GPS_ASSERT(a_mode_needs_power,
    m_axis_tvalid && (m_axis_tdata[4:3] != MODE_IDLE) |-> m_axis_tdata[0])
  `GPS_ASSERT(a_mode_legal,
    m_axis_tvalid |-> (m_axis_tdata[4:3] == MODE_IDLE) ||
      (m_axis_tdata[4:3] == MODE_BROWNOUT) || (m_axis_tdata[4:3] == MODE_SHUTDOWN))
  // a draining output always frees the input side
  `GPS_ASSERT_ALWAYS(a_no_bubble, rst_ni && m_axis_tready |-> s_axis_tready)
  `GPS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=>
    m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind graceful_power_sequencer_unit gps_checker u_gps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

/* bench/tb_graceful_power_sequencer_unit.sv */
`timescale 1ns / 1ps
module tb_graceful_power_sequencer_unit;
  import gps_pkg::*;

  // bit order matches m_axis_tdata[4:0]
  typedef struct packed {
    mode_e mode;
    logic  led;
    logic  halt;
    logic  power;
  } host_status_t;

  // levels are {ext_power, button_n, safe_n}
  typedef struct {
    logic [2:0]   lv;
    logic         typed;
    host_status_t status;
  } dir_row_t;

  localparam host_status_t HostOffIdle = '{mode: MODE_IDLE, led: 1'b0, halt: 1'b0, power: 1'b0};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic         calm_stretch = 1'b0;
  int unsigned  mismatch_count = 0;
  host_status_t expected_status[$];
  dir_row_t     dir_rows[$];

  // shadow of the sequencer state
  cfg_t        shadow_cfg = CfgReset;
  mode_e       p_mode = MODE_IDLE;
  logic        p_power = 1'b0;
  logic        p_led = 1'b0;
  logic        p_halt = 1'b0;
  logic [5:0]  p_blinks = '0;
  logic [16:0] p_slow_cnt = '0;
  logic        p_slow_run = 1'b0;
  logic [16:0] p_deb_cnt = '0;
  logic        p_deb_run = 1'b0;
  logic [2:0]  p_last = 3'b011;

  graceful_power_sequencer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm_stretch || ($urandom_range(0, 99) >= 10);
  end

  function automatic void host_off();
    p_power    = 1'b0;
    p_led      = 1'b0;
    p_halt     = 1'b0;
    p_mode     = MODE_IDLE;
    p_blinks   = '0;
    p_slow_run = 1'b0;
    p_slow_cnt = '0;
  endfunction

  function automatic void host_on();
    p_power = 1'b1;
    p_led   = 1'b1;
  endfunction

  function automatic void start_shutdown();
    p_halt     = 1'b1;
    p_mode     = MODE_SHUTDOWN;
    p_slow_cnt = '0;
    p_slow_run = 1'b1;
  endfunction

  // one base tick: timers first, then SAFE/button changes, then supply changes
  function automatic host_status_t sequencer_tick(logic [2:0] lv);
    logic [2:0]   chg;
    logic [15:0]  period;
    host_status_t st;
    chg = lv ^ p_last;
    if (p_deb_run) begin
      p_deb_cnt = p_deb_cnt + 17'd1;
      if (p_deb_cnt >= shadow_cfg.debounce_ticks) begin
        p_deb_run = 1'b0;
        p_deb_cnt = '0;
        if (!lv[1]) begin
          if (!p_power && lv[2]) begin
            if (p_mode == MODE_IDLE) host_on();
          end else if (p_power) begin
            start_shutdown();
          end
        end
      end
    end
    if (p_slow_run) begin
      period = (p_mode == MODE_SHUTDOWN) ? shadow_cfg.blink_ticks : shadow_cfg.brownout_ticks;
      p_slow_cnt = p_slow_cnt + 17'd1;
      if (p_slow_cnt >= period) begin
        p_slow_cnt = '0;
        case (p_mode)
          MODE_BROWNOUT: begin
            p_slow_run = 1'b0;
            if (!lv[2]) start_shutdown();
          end
          MODE_SHUTDOWN: begin
            p_blinks = p_blinks + 6'd1;
            if (p_blinks < shadow_cfg.shutdown_blinks) p_led = ~p_led;
            else host_off();
          end
          default: p_slow_run = 1'b0;
        endcase
      end
    end
    if (chg[1:0] != 2'b00) begin
      if (!lv[0]) host_off();
      if (!lv[1]) begin
        p_deb_cnt = '0;
        p_deb_run = 1'b1;
      end
    end
    if (chg[2]) begin
      if (lv[2]) begin
        if (p_mode != MODE_SHUTDOWN) begin
          p_mode = MODE_IDLE;
          if (shadow_cfg.wake_on_supply) host_on();
        end
      end else if (p_power) begin
        p_mode     = MODE_BROWNOUT;
        p_slow_cnt = '0;
        p_slow_run = 1'b1;
      end
    end
    p_last   = lv;
    st.power = p_power;
    st.halt  = p_halt;
    st.led   = p_led;
    st.mode  = p_mode;
    return st;
  endfunction

  function automatic int capped(int v, int c);
    return (v > c) ? c : v;
  endfunction

  function automatic void add_row(logic [2:0] lv, logic typed, host_status_t st);
    dir_rows.push_back('{lv: lv, typed: typed, status: st});
  endfunction

  task automatic send_levels(input logic [2:0] lv, input logic typed,
                             input host_status_t typed_status);
    host_status_t predicted;
    if (!calm_stretch && $urandom_range(0, 99) < 4) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, lv};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    predicted = sequencer_tick(lv);
    expected_status.push_back(typed ? typed_status : predicted);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // valid stays high across back-to-back writes; caller lowers it
  task automatic cfg_write(input cfg_idx_e idx, input int data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 16'(data);
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    case (idx)
      CFG_DEBOUNCE_TICKS:  shadow_cfg.debounce_ticks  = 16'(data);
      CFG_BROWNOUT_TICKS:  shadow_cfg.brownout_ticks  = 16'(data);
      CFG_BLINK_TICKS:     shadow_cfg.blink_ticks     = 16'(data);
      CFG_SHUTDOWN_BLINKS: shadow_cfg.shutdown_blinks = 6'(data);
      CFG_WAKE_ON_SUPPLY:  shadow_cfg.wake_on_supply  = 1'(data);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int deb, input int brown, input int blink,
                                input int blinks, input int auto_on);
    wait_drain();
    cfg_write(CFG_DEBOUNCE_TICKS, deb);
    cfg_write(CFG_BROWNOUT_TICKS, brown);
    cfg_write(CFG_BLINK_TICKS, blink);
    cfg_write(CFG_SHUTDOWN_BLINKS, blinks);
    cfg_write(CFG_WAKE_ON_SUPPLY, auto_on);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed presses, supply drops and quiet stretches held for the timer
  // spans (capped) so that short timers fire; a few short glitches mixed in
  task automatic run_phase(input int n, input int calm_len);
    logic [2:0] lv;
    int         hold;
    int         r;
    int         deb_span;
    int         brown_span;
    int         quiet_span;
    lv         = 3'b111;
    hold       = 0;
    deb_span   = capped(shadow_cfg.debounce_ticks, 200);
    brown_span = capped(shadow_cfg.brownout_ticks, 200);
    quiet_span = capped(shadow_cfg.blink_ticks * shadow_cfg.shutdown_blinks + 4, 250);
    for (int i = 0; i < n; i++) begin
      calm_stretch = (i < calm_len);
      if (i == n / 2) wait_drain();
      if (hold <= 0) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          lv   = 3'($urandom_range(0, 7));
          hold = $urandom_range(1, 2);
        end else if (r < 10) begin
          lv   = {lv[2], 2'b10};
          hold = $urandom_range(1, 2);
        end else if (r < 45) begin
          lv   = {lv[2], 2'b01};
          hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, deb_span)
                                             : deb_span + $urandom_range(0, 3);
        end else if (r < 60) begin
          lv   = 3'b011;
          hold = $urandom_range(0, 1) ? $urandom_range(1, brown_span)
                                      : brown_span + $urandom_range(0, 4);
        end else begin
          lv   = 3'b111;
          hold = ($urandom_range(0, 9) < 3) ? $urandom_range(1, quiet_span)
                                            : $urandom_range(1, 8);
        end
      end
      send_levels(lv, 1'b0, HostOffIdle);
      hold--;
    end
    calm_stretch = 1'b0;
  endtask

  always @(negedge clk_i) begin
    host_status_t got;
    host_status_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = host_status_t'(m_axis_tdata[4:0]);
      if (expected_status.size() == 0) begin
        $error("status beat with nothing expected: %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_status.pop_front();
        if (got.power !== want.power) begin
          $error("power_enable: expected %0d, got %0d", want.power, got.power);
          mismatch_count++;
        end
        if (got.halt !== want.halt) begin
          $error("halt_request: expected %0d, got %0d", want.halt, got.halt);
          mismatch_count++;
        end
        if (got.led !== want.led) begin
          $error("led_drive: expected %0d, got %0d", want.led, got.led);
          mismatch_count++;
        end
        if (got.mode !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, got.mode);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("graceful_power_sequencer_unit verification failed");
    $finish;
  end

  initial begin
    add_row(3'b011, 1'b1, HostOffIdle);              // levels as at reset
    add_row(3'b111, 1'b1, HostOffIdle);              // supply arrives, no auto power-on
    repeat (6) add_row(3'b101, 1'b0, HostOffIdle);   // press held through debounce
    add_row(3'b111, 1'b0, HostOffIdle);
    add_row(3'b110, 1'b1, HostOffIdle);              // SAFE low cuts at once
    add_row(3'b111, 1'b1, HostOffIdle);
    repeat (6) add_row(3'b101, 1'b0, HostOffIdle);
    add_row(3'b011, 1'b0, HostOffIdle);              // supply lost while on
    add_row(3'b101, 1'b0, HostOffIdle);              // supply back with a press
    repeat (5) add_row(3'b101, 1'b0, HostOffIdle);   // press while on: shutdown
    add_row(3'b011, 1'b0, HostOffIdle);              // supply lost during shutdown
    add_row(3'b000, 1'b1, HostOffIdle);              // all lines low
    add_row(3'b111, 1'b0, HostOffIdle);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_levels(dir_rows[i].lv, dir_rows[i].typed, dir_rows[i].status);

    apply_settings(1, 1, 1, 1, 1);
    run_phase(250, 0);
    apply_settings(3, 10, 4, 5, 0);
    run_phase(400, 250);
    apply_settings(65535, 65535, 65535, 63, 1);
    run_phase(150, 0);
    apply_settings(2, 6, 2, 63, 0);
    run_phase(400, 0);
    apply_settings($urandom_range(1, 8), $urandom_range(1, 30), $urandom_range(1, 6),
                   $urandom_range(1, 20), $urandom_range(0, 1));
    run_phase(550, 0);

    s_axis_tvalid <= 1'b0;
    for (int w = 0; w < 20000 && expected_status.size() != 0; w++) @(posedge clk_i);
    if (expected_status.size() != 0) begin
      $error("%0d status beats never arrived", expected_status.size());
      mismatch_count++;
    end
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("graceful_power_sequencer_unit verification clean");
    end else begin
      $display("graceful_power_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule
